[sv/tws_pkg.sv]
// ----------------------------------------------------------------------------
// tws_pkg: shared types and constants of the two-way stack
// Store size, action and status codes, and the command/status bundles that
// run between the controller and the datapath.
// ----------------------------------------------------------------------------
package tws_pkg;

  localparam int DEPTH = 16;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int WW    = 32;

  localparam logic [CW-1:0] DEPTH_CW = CW'(DEPTH);

  typedef enum logic [1:0] {
    ACT_PUSH = 2'd0,
    ACT_POP  = 2'd1,
    ACT_DUMP = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_EMPTY     = 2'd3
  } status_t;

  // Controller to datapath
  typedef struct packed {
    logic    in_ready;   // take the request on the input channel
    logic    push_wr;    // write the pushed word, grow the side's count
    logic    pop_dec;    // shrink the side's count
    logic    rd_top;     // read the side's top entry, start the walk
    logic    rd_next;    // read the next entry of the walk
    logic    out_imm;    // load a result that needs no store read
    logic    out_mem;    // load a result from the store read data
    status_t imm_status; // status of an immediate result
  } tws_cmd_t;

  // Datapath to controller
  typedef struct packed {
    action_t action;     // action of the request on the input channel
    logic    full;       // both stacks together fill the store
    logic    side_empty; // the requested side holds no word
    logic    one_left;   // the word being read is the final one of the walk
    logic    out_free;   // output register can take a result this cycle
  } tws_stat_t;

endpackage

[sv/tws_dp.sv]
// ----------------------------------------------------------------------------
// tws_dp: two-way stack datapath
// Stack counts, the shared word store with a registered read port, the walk
// pointer for pops and dumps, and the output register.
// ----------------------------------------------------------------------------
module tws_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  tws_pkg::tws_cmd_t                 cmd,
  output tws_pkg::tws_stat_t                stat,
  input  logic [1:0]                        in_action,
  input  logic                              in_side,
  input  logic signed [tws_pkg::WW-1:0]     in_push_value,
  output logic                              out_valid,
  input  logic                              out_tready,
  output tws_pkg::status_t                  out_status,
  output logic signed [tws_pkg::WW-1:0]     out_data_word,
  output logic                              out_last
);
  import tws_pkg::*;

  logic [WW-1:0] mem [DEPTH];
  logic [WW-1:0] rd_data_r;

  logic [CW-1:0] low_cnt_r,  low_cnt_nxt;
  logic [CW-1:0] high_cnt_r, high_cnt_nxt;
  logic [CW-1:0] rem_r,      rem_nxt;
  logic [AW-1:0] ptr_r,      ptr_nxt;
  logic          side_r,     side_nxt;
  logic          out_valid_r, out_valid_nxt;
  status_t       out_status_r;
  logic [WW-1:0] out_word_r;
  logic          out_last_r;

  logic [CW:0]   cnt_sum;
  logic [CW-1:0] side_cnt;
  logic [AW-1:0] top_addr;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] ptr_step;
  logic [AW-1:0] rd_addr;
  logic          rd_en;
  action_t       action;

  assign action   = action_t'(in_action);
  assign cnt_sum  = {1'b0, low_cnt_r} + {1'b0, high_cnt_r};
  assign side_cnt = in_side ? high_cnt_r : low_cnt_r;

  // Top entry: just below the low count, or just above the high side's free space
  assign top_addr = in_side ? AW'(DEPTH_CW - side_cnt) : AW'(side_cnt - CW'(1));
  assign wr_addr  = in_side ? AW'(DEPTH_CW - CW'(1) - high_cnt_r) : AW'(low_cnt_r);
  // Walk toward the side's base
  assign ptr_step = side_r ? ptr_r + AW'(1) : ptr_r - AW'(1);

  assign rd_en   = cmd.rd_top | cmd.rd_next;
  assign rd_addr = cmd.rd_top ? top_addr : ptr_step;

  assign stat.action     = action;
  assign stat.full       = (cnt_sum == (CW+1)'(DEPTH));
  assign stat.side_empty = (side_cnt == '0);
  assign stat.one_left   = (rem_r == CW'(1));
  assign stat.out_free   = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (cmd.push_wr) begin
      mem[wr_addr] <= in_push_value;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_comb begin
    low_cnt_nxt   = low_cnt_r;
    high_cnt_nxt  = high_cnt_r;
    rem_nxt       = rem_r;
    ptr_nxt       = ptr_r;
    side_nxt      = side_r;
    out_valid_nxt = out_valid_r;

    if (cmd.push_wr) begin
      if (in_side) high_cnt_nxt = high_cnt_r + CW'(1);
      else         low_cnt_nxt  = low_cnt_r + CW'(1);
    end
    if (cmd.pop_dec) begin
      if (in_side) high_cnt_nxt = high_cnt_r - CW'(1);
      else         low_cnt_nxt  = low_cnt_r - CW'(1);
    end

    if (cmd.rd_top) begin
      ptr_nxt  = top_addr;
      side_nxt = in_side;
      rem_nxt  = (action == ACT_POP) ? CW'(1) : side_cnt;
    end else if (cmd.rd_next) begin
      ptr_nxt = ptr_step;
      rem_nxt = rem_r - CW'(1);
    end

    if (cmd.out_imm || cmd.out_mem) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_cnt_r   <= '0;
      high_cnt_r  <= '0;
      rem_r       <= '0;
      ptr_r       <= '0;
      side_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      low_cnt_r   <= low_cnt_nxt;
      high_cnt_r  <= high_cnt_nxt;
      rem_r       <= rem_nxt;
      ptr_r       <= ptr_nxt;
      side_r      <= side_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Output payload: no reset
  always_ff @(posedge clk) begin
    if (cmd.out_imm) begin
      out_status_r <= cmd.imm_status;
      out_word_r   <= (cmd.imm_status == ST_OK) ? in_push_value : '0;
      out_last_r   <= 1'b1;
    end else if (cmd.out_mem) begin
      out_status_r <= ST_OK;
      out_word_r   <= rd_data_r;
      out_last_r   <= stat.one_left;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_data_word = out_word_r;
  assign out_last      = out_last_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_sum <= (CW+1)'(DEPTH))
    else $error("stack counts exceed the store size");

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push_wr |=> cnt_sum == $past(cnt_sum) + (CW+1)'(1))
    else $error("push did not grow the stack counts by one");

  a_walk_remaining: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_next |-> rem_r > CW'(1))
    else $error("walk stepped past the final word");

endmodule

[sv/tws_ctrl.sv]
// ----------------------------------------------------------------------------
// tws_ctrl: two-way stack controller
// Takes requests, decides on overflow and empty cases, and steps pop and
// dump reads through the store one word per output transfer.
// ----------------------------------------------------------------------------
module tws_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  input  tws_pkg::tws_stat_t stat,
  output tws_pkg::tws_cmd_t  cmd
);
  import tws_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_DATA = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic   take;

  assign take = (state_r == S_IDLE) && in_tvalid && stat.out_free;

  always_comb begin
    cmd            = '0;
    cmd.imm_status = ST_OK;
    cmd.in_ready   = (state_r == S_IDLE) && stat.out_free;
    state_nxt      = state_r;

    unique case (state_r)
      S_IDLE: begin
        if (take) begin
          case (stat.action)
            ACT_PUSH: begin
              cmd.out_imm    = 1'b1;
              cmd.imm_status = stat.full ? ST_OVERFLOW : ST_OK;
              cmd.push_wr    = !stat.full;
            end
            ACT_POP: begin
              if (stat.side_empty) begin
                cmd.out_imm    = 1'b1;
                cmd.imm_status = ST_UNDERFLOW;
              end else begin
                cmd.pop_dec = 1'b1;
                cmd.rd_top  = 1'b1;
                state_nxt   = S_DATA;
              end
            end
            ACT_DUMP: begin
              if (stat.side_empty) begin
                cmd.out_imm    = 1'b1;
                cmd.imm_status = ST_EMPTY;
              end else begin
                cmd.rd_top = 1'b1;
                state_nxt  = S_DATA;
              end
            end
            default: ; // drop unknown actions
          endcase
        end
      end
      S_DATA: begin
        // Hand over the read word and fetch the next one in the same cycle
        if (stat.out_free) begin
          cmd.out_mem = 1'b1;
          if (stat.one_left) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.rd_next = 1'b1;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_one_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.out_imm && cmd.out_mem))
    else $error("two result sources in one cycle");

  a_walk_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DATA && cmd.out_mem && stat.one_left) |=> state_r == S_IDLE)
    else $error("walk did not return to idle after the final word");

  a_no_take_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DATA) |-> !cmd.push_wr && !cmd.pop_dec && !cmd.rd_top)
    else $error("new request handled during a walk");

endmodule

[sv/two_way_stack_top.sv]
// ----------------------------------------------------------------------------
// two_way_stack_top: two stacks in one shared word store
// Stack side 0 grows up from entry 0, side 1 grows down from the last entry.
// ----------------------------------------------------------------------------
// A push, or any request that fails (overflow, underflow, dump of an empty
// side), gives its single result in the output register in the cycle after
// it is taken. A pop first reads the store, whose read port is registered,
// and then hands the word over. On a dump, the store's single read port
// delivers one word per cycle while the output side keeps tready high, the
// next read overlapping the current transfer. A new request is taken only
// when the previous one has handed over its final result to the output
// register and that register is free or being emptied. The store needs no
// clearing pass after reset.
module two_way_stack_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,  // [31:0] push_value
  input  logic [2:0]  in_tuser,  // [1:0] action, [2] side
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata, // [31:0] data_word
  output logic [1:0]  out_tuser, // [1:0] status
  output logic        out_tlast
);
  import tws_pkg::*;

  tws_cmd_t  cmd;
  tws_stat_t stat;
  status_t   out_status;
  logic signed [WW-1:0] out_data_word;

  tws_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .stat      (stat),
    .cmd       (cmd)
  );

  tws_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .in_action     (in_tuser[1:0]),
    .in_side       (in_tuser[2]),
    .in_push_value (in_tdata),
    .out_valid     (out_tvalid),
    .out_tready    (out_tready),
    .out_status    (out_status),
    .out_data_word (out_data_word),
    .out_last      (out_tlast)
  );

  assign in_tready = cmd.in_ready;
  assign out_tdata = out_data_word;
  assign out_tuser = out_status;

endmodule

[tb/tws_tb_pkg.sv]
// ----------------------------------------------------------------------------
// tws_tb_pkg: shadow model and result checker for the two-way stack
// Keeps its own copy of the shared store and both stack depths. Each accepted
// request is turned into the results that the block must return. Each
// returned result is compared with the oldest outstanding one.
// ----------------------------------------------------------------------------
package tws_tb_pkg;

  import tws_pkg::*;

  typedef struct {
    status_t       status;
    logic [WW-1:0] word;
    logic          last;
  } stack_result_t;

  class stack_shadow;

    logic [WW-1:0] words [DEPTH];
    int unsigned   low_used;
    int unsigned   high_used;
    stack_result_t due_results [$];
    int unsigned   mismatches;

    function new();
      low_used   = 0;
      high_used  = 0;
      mismatches = 0;
    endfunction

    function int unsigned side_used(logic side);
      return side ? high_used : low_used;
    endfunction

    function void add_result(status_t status, logic [WW-1:0] word, logic last);
      stack_result_t r;
      r.status = status;
      r.word   = word;
      r.last   = last;
      due_results.push_back(r);
    endfunction

    function void note_request(logic [1:0] act, logic side, logic [WW-1:0] value);
      int unsigned used;
      int unsigned idx;
      used = side_used(side);
      case (act)
        ACT_PUSH: begin
          if (low_used + high_used >= DEPTH) begin
            add_result(ST_OVERFLOW, '0, 1'b1);
          end else if (!side) begin
            words[low_used] = value;
            low_used++;
            add_result(ST_OK, value, 1'b1);
          end else begin
            words[DEPTH - 1 - high_used] = value;
            high_used++;
            add_result(ST_OK, value, 1'b1);
          end
        end
        ACT_POP: begin
          if (used == 0) begin
            add_result(ST_UNDERFLOW, '0, 1'b1);
          end else if (!side) begin
            low_used--;
            add_result(ST_OK, words[low_used], 1'b1);
          end else begin
            high_used--;
            add_result(ST_OK, words[DEPTH - 1 - high_used], 1'b1);
          end
        end
        ACT_DUMP: begin
          if (used == 0) begin
            add_result(ST_EMPTY, '0, 1'b1);
          end else begin
            // walk from the top of the side down to its base
            for (int unsigned i = 0; i < used; i++) begin
              idx = side ? (DEPTH - used + i) : (used - 1 - i);
              add_result(ST_OK, words[idx], (i + 1 == used));
            end
          end
        end
        default: ;
      endcase
    endfunction

    function void check_result(logic [1:0] status, logic [WW-1:0] word, logic last);
      stack_result_t exp;
      if (due_results.size() == 0) begin
        $error("unexpected result: status %0d, data_word %h, last %0b", status, word, last);
        mismatches++;
        return;
      end
      exp = due_results.pop_front();
      if (status !== exp.status) begin
        $error("status: expected %0d, got %0d", exp.status, status);
        mismatches++;
      end
      if (word !== exp.word) begin
        $error("data_word: expected %h, got %h", exp.word, word);
        mismatches++;
      end
      if (last !== exp.last) begin
        $error("last: expected %0b, got %0b", exp.last, last);
        mismatches++;
      end
    endfunction

  endclass

endpackage

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb: testbench of the two-way stack
// Drives push, pop and dump requests on both sides over the input stream,
// with random source gaps and sink stalls, and checks every result against
// a shadow copy of the two stacks.
// ----------------------------------------------------------------------------
module tb;

  timeunit 1ns;
  timeprecision 1ps;

  import tws_pkg::*;
  import tws_tb_pkg::*;

  // action code outside the defined set; the block drops it
  localparam logic [1:0] ACT_IGNORED = 2'd3;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;   // [31:0] push_value
  logic [2:0]  in_tuser;   // [1:0] action, [2] side
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;  // [31:0] data_word
  logic [1:0]  out_tuser;  // [1:0] status
  logic        out_tlast;

  int unsigned sender_idle_pct = 0;
  int unsigned stall_pct = 0;

  stack_shadow shadow;

  two_way_stack_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("tb failed");
    $finish;
  end

  always @(negedge clk) begin
    out_tready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      shadow.check_result(out_tuser, out_tdata, out_tlast);
    end
  end

  function automatic logic [31:0] pick_word();
    case ($urandom_range(11))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'hFFFF_FFFF;
      3:       return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_request(input logic [1:0] act, input logic side,
                              input logic [31:0] value);
    while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= {side, act};
    in_tdata  <= value;
    do @(posedge clk); while (!in_tready);
    shadow.note_request(act, side, value);
    @(negedge clk);
  endtask

  // filling leans toward pushes so the stacks meet; otherwise lean toward pops
  task automatic send_random(input bit filling, output bit counted);
    int unsigned pick;
    logic [1:0]  act;
    logic        side;
    pick = $urandom_range(99);
    side = 1'($urandom_range(1));
    if (pick < 2) begin
      act = ACT_IGNORED;
    end else if (pick < 17) begin
      act = ACT_DUMP;
    end else if (pick < (filling ? 77 : 37)) begin
      act = ACT_PUSH;
    end else begin
      act = ACT_POP;
    end
    send_request(act, side, pick_word());
    counted = (act != ACT_IGNORED);
  endtask

  initial begin : stimulus
    int unsigned counted_items;
    int unsigned steps;
    bit          filling;
    bit          counted;

    shadow    = new();
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // empty sides, dropped action code
    send_request(ACT_DUMP, 1'b0, 32'h0);
    send_request(ACT_DUMP, 1'b1, 32'h0);
    send_request(ACT_POP, 1'b0, 32'h0);
    send_request(ACT_POP, 1'b1, 32'h0);
    send_request(ACT_IGNORED, 1'b0, 32'h1234_5678);

    // fill the store from both ends with extreme words first, then overflow
    for (int i = 0; i < DEPTH; i++) begin
      case (i)
        0:       send_request(ACT_PUSH, i[0], 32'h8000_0000);
        1:       send_request(ACT_PUSH, i[0], 32'h7FFF_FFFF);
        2:       send_request(ACT_PUSH, i[0], 32'hFFFF_FFFF);
        3:       send_request(ACT_PUSH, i[0], 32'h0000_0000);
        default: send_request(ACT_PUSH, i[0], $urandom);
      endcase
    end
    send_request(ACT_PUSH, 1'b0, 32'h5A5A_5A5A);
    send_request(ACT_PUSH, 1'b1, 32'hA5A5_A5A5);
    send_request(ACT_DUMP, 1'b0, 32'h0);
    send_request(ACT_DUMP, 1'b1, 32'h0);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin sender_idle_pct = 0;  stall_pct = 0;  end
        1:       begin sender_idle_pct = 45; stall_pct = 0;  end
        2:       begin sender_idle_pct = 0;  stall_pct = 45; end
        default: begin sender_idle_pct = 26; stall_pct = 26; end
      endcase
      counted_items = 0;
      steps = 0;
      filling = 1'b0;
      while (counted_items < 31) begin
        if (steps % 15 == 14) filling = !filling;
        send_random(filling, counted);
        if (counted) counted_items++;
        steps++;
      end
    end
    in_tvalid <= 1'b0;

    while (shadow.due_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (shadow.mismatches == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
